### hw/rtl/olst_pkg.sv
// ----------------------------------------------------------------------------
// olst_pkg
// Shared constants, operation and status codes, and the controller command
// struct of the ordered list store.
// ----------------------------------------------------------------------------
package olst_pkg;

	localparam int DEPTH       = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int FUNC_W      = 2;
	localparam int POS_W       = 5;
	localparam int VAL_IN_W    = 32;
	localparam int STATUS_W    = 2;
	localparam int CNT_W       = 5;
	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 8;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_REMOVE = 2'd2,
		FUNC_QUERY  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef struct packed {
		logic load;    // capture the accepted item
		logic commit;  // run the operation and register its result
	} cmd_t;

endpackage

### hw/rtl/olst_ctrl.sv
// ----------------------------------------------------------------------------
// olst_ctrl
// Controller: sequences capture and execution of one item and keeps the
// result-valid flag of the output register.
// ----------------------------------------------------------------------------
module olst_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output olst_pkg::cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign s_tready   = (state_q == S_IDLE);
	assign cmd.load   = s_tvalid && (state_q == S_IDLE);
	// execute only when the output register is free or is being emptied
	assign cmd.commit = (state_q == S_EXEC) && (!out_valid_q || m_tready);
	assign m_tvalid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_commit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("result not presented after execute");

	a_load_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_EXEC) && !s_tready)
		else $error("captured item not taken to execute");

	a_no_double_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.commit))
		else $error("capture and execute in the same cycle");
`endif

endmodule

### hw/rtl/olst_dpath.sv
// ----------------------------------------------------------------------------
// olst_dpath
// Datapath: a row of value cells that compare in parallel and shift up on
// insert or down on remove, the entry count, and the result register.
// ----------------------------------------------------------------------------
module olst_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  olst_pkg::cmd_t                      cmd,
	input  logic [olst_pkg::FUNC_W-1:0]         func,
	input  logic [olst_pkg::POS_W-1:0]          position,
	input  logic [olst_pkg::VAL_IN_W-1:0]       value,
	output logic [olst_pkg::STATUS_W-1:0]       status,
	output logic                                found,
	output logic [olst_pkg::CNT_W-1:0]          count
);

	localparam int DEPTH = olst_pkg::DEPTH;
	localparam int VW    = olst_pkg::VALUE_WIDTH;
	localparam int CW    = olst_pkg::CNT_W;

	olst_pkg::func_t        func_q;
	logic [CW-1:0]          pos_q;
	logic [VW-1:0]          val_q;
	logic [VW-1:0]          cell_q [DEPTH];
	logic [VW-1:0]          cell_d [DEPTH];
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          count_d;
	olst_pkg::status_t      status_d;
	logic                   found_d;
	logic [olst_pkg::STATUS_W-1:0] status_q;
	logic                   found_q;
	logic [CW-1:0]          count_out_q;

	logic [DEPTH-1:0] match;
	logic [DEPTH-1:0] after;
	logic             hit;
	logic             is_ins;
	logic [CW-1:0]    ins_pos;
	logic             ins_ok;
	logic             rm_ok;

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= olst_pkg::func_t'(func);
			pos_q  <= CW'(position);
			val_q  <= value[VW-1:0];
		end
	end

	always_comb begin
		logic acc;
		acc = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			match[i] = (CW'(i) < count_q) && (cell_q[i] == val_q);
			acc      = acc | match[i];
			after[i] = acc;
		end
		hit = acc;
	end

	assign is_ins  = (func_q == olst_pkg::FUNC_INSERT) || (func_q == olst_pkg::FUNC_APPEND);
	assign ins_pos = (func_q == olst_pkg::FUNC_APPEND) ? count_q : pos_q;
	assign ins_ok  = is_ins && (ins_pos <= count_q) && (count_q < CW'(DEPTH));
	assign rm_ok   = (func_q == olst_pkg::FUNC_REMOVE) && hit;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_d[i] = cell_q[i];
		end
		if (ins_ok) begin
			for (int i = 1; i < DEPTH; i++) begin
				if (CW'(i) > ins_pos) begin
					cell_d[i] = cell_q[i-1];
				end
			end
			for (int i = 0; i < DEPTH; i++) begin
				if (CW'(i) == ins_pos) begin
					cell_d[i] = val_q;
				end
			end
		end else if (rm_ok) begin
			// close the gap from the first match upward
			for (int i = 0; i < DEPTH - 1; i++) begin
				if (after[i]) begin
					cell_d[i] = cell_q[i+1];
				end
			end
		end
	end

	always_comb begin
		status_d = olst_pkg::ST_OK;
		found_d  = 1'b0;
		count_d  = count_q;
		if (is_ins) begin
			if (ins_pos > count_q) begin
				status_d = olst_pkg::ST_BAD_POS;
			end else if (count_q >= CW'(DEPTH)) begin
				status_d = olst_pkg::ST_FULL;
			end else begin
				count_d = count_q + CW'(1);
			end
		end else if (!hit) begin
			status_d = olst_pkg::ST_MISSING;
		end else begin
			found_d = 1'b1;
			if (rm_ok) begin
				count_d = count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < DEPTH; i++) begin
				cell_q[i] <= cell_d[i];
			end
			status_q    <= status_d;
			found_q     <= found_d;
			count_out_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
		end
	end

	assign status = status_q;
	assign found  = found_q;
	assign count  = count_out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(count_q))
		else $error("entry count changed without execute");

	a_query_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (func_q == olst_pkg::FUNC_QUERY) |=> $stable(count_q))
		else $error("query changed the list");
`endif

endmodule

### hw/rtl/ordered_list_store_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_store_unit
// Ordered list of up to 16 values with insert, append, remove and query.
// ----------------------------------------------------------------------------
// The controller captures an accepted item, then executes it in the single cell
// array update once the output register is free or being emptied; the result
// is then held in the output register. A new item is taken once that is done.
// The output register lets the next item be taken while a result waits.
// Reset clears the entry count and the handshake state; cell contents are
// undefined until written.
module ordered_list_store_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// func[1:0], position[6:2], value[38:7], zero[39]
	input  logic [olst_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// status[1:0], found[2], count[7:3]
	output logic [olst_pkg::OUT_DATA_W-1:0]    m_tdata
);

	olst_pkg::cmd_t                  cmd;
	logic [olst_pkg::STATUS_W-1:0]   status;
	logic                            found;
	logic [olst_pkg::CNT_W-1:0]      count;

	olst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	olst_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.func     (s_tdata[1:0]),
		.position (s_tdata[6:2]),
		.value    (s_tdata[38:7]),
		.status   (status),
		.found    (found),
		.count    (count)
	);

	assign m_tdata = {count, found, status};

endmodule
